@@ rtl/pcc_pkg.sv @@
// Shared types and constants of the two-by-two phase chi-square classifier.
`default_nettype none
package pcc_pkg;

  localparam int TOTAL_W   = 18;
  localparam int CHI_W     = 40;
  localparam int RAND_W    = 60;
  localparam int EPS_BITS  = 16;
  localparam int EPS_W     = 17;
  localparam int CFG_IDX_W = 1;
  localparam int VERDICT_W = 3;

  localparam logic [CHI_W-1:0] CHI_MAX      = {CHI_W{1'b1}};
  localparam logic [EPS_W-1:0] EPS_ONE      = 17'h10000;
  localparam logic [EPS_W-1:0] EPS_RESET    = 17'd6554;
  localparam logic [CHI_W-1:0] THRESH_RESET = 40'd327680;

  localparam logic [CFG_IDX_W-1:0] CFG_EPSILON   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b1;

  localparam logic [VERDICT_W-1:0] V_IN_PHASE      = 3'd0;
  localparam logic [VERDICT_W-1:0] V_OUT_OF_PHASE  = 3'd1;
  localparam logic [VERDICT_W-1:0] V_UNRELIABLE    = 3'd2;
  localparam logic [VERDICT_W-1:0] V_ZERO_COVERAGE = 3'd3;
  localparam logic [VERDICT_W-1:0] V_SHARED_CHAIN  = 3'd4;
  localparam logic [VERDICT_W-1:0] V_SHARED_ANCHOR = 3'd5;

  typedef struct packed {
    logic                 valid;
    logic                 rejected;
    logic [VERDICT_W-1:0] verdict;
  } pcc_ctl_t;

endpackage
`default_nettype wire

@@ rtl/two_by_two_phase_chi_square_classifier_unit.sv @@
// Top level of the two-by-two phase chi-square classifier: four cell lanes and a merge.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-----------------------------------------------
//  input    | start, busy         | in_cell_*, in_*_coverage_*, in_shared_*
//  result   | out_valid (strobe)  | out_verdict, out_chi_in_phase, out_chi_out_of_phase
//  config   | cfg_we              | cfg_index, cfg_wdata
//
// One transaction is taken every cycle; busy is always low.
// Each accepted transaction runs through the bit-per-stage random and chi-square dividers.
// Synchronous reset clears the pipeline valid bits and restores both registers.
// Results show for one cycle only; the receiver cannot stall the block.
`default_nettype none
module two_by_two_phase_chi_square_classifier_unit #(
  parameter int COUNT_WIDTH   = 16,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [COUNT_WIDTH-1:0]          in_cell_00,
  input  wire logic [COUNT_WIDTH-1:0]          in_cell_01,
  input  wire logic [COUNT_WIDTH-1:0]          in_cell_10,
  input  wire logic [COUNT_WIDTH-1:0]          in_cell_11,
  input  wire logic [COUNT_WIDTH-1:0]          in_entrance_coverage_0,
  input  wire logic [COUNT_WIDTH-1:0]          in_entrance_coverage_1,
  input  wire logic [COUNT_WIDTH-1:0]          in_exit_coverage_0,
  input  wire logic [COUNT_WIDTH-1:0]          in_exit_coverage_1,
  input  wire logic [pcc_pkg::TOTAL_W-1:0]     in_total_coverage,
  input  wire logic                            in_shared_chain,
  input  wire logic                            in_shared_anchor,
  output logic                                 out_valid,
  output logic      [pcc_pkg::VERDICT_W-1:0]   out_verdict,
  output logic      [pcc_pkg::CHI_W-1:0]       out_chi_in_phase,
  output logic      [pcc_pkg::CHI_W-1:0]       out_chi_out_of_phase,
  input  wire logic                            cfg_we,
  input  wire logic [pcc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pcc_pkg::CHI_W-1:0]       cfg_wdata
);
  import pcc_pkg::*;

  localparam int CTL_LAT = 2 * COUNT_WIDTH + FRACTION_BITS + 49;
  localparam int OUT_LAT = CTL_LAT + 2;

  logic [EPS_W-1:0] epsilon_r;
  logic [CHI_W-1:0] threshold_r;
  logic [EPS_W-1:0] eps_eff;
  logic             accept;
  logic             zero_cov;
  pcc_ctl_t         ctl_nxt;
  pcc_ctl_t         ctl_r [CTL_LAT];

  logic [CHI_W-1:0] mix00, rnd00, mix01, rnd01, mix10, rnd10, mix11, rnd11;
  logic [3:0][CHI_W-1:0] terms_in, terms_out;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epsilon_r   <= EPS_RESET;
      threshold_r <= THRESH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EPSILON:   epsilon_r   <= cfg_wdata[EPS_W-1:0];
        CFG_THRESHOLD: threshold_r <= cfg_wdata;
        default:       ;
      endcase
    end
  end

  // Weights above one count as exactly one
  assign eps_eff = (epsilon_r > EPS_ONE) ? EPS_ONE : epsilon_r;

  assign zero_cov = (in_entrance_coverage_0 == '0) || (in_entrance_coverage_1 == '0) ||
                    (in_exit_coverage_0 == '0) || (in_exit_coverage_1 == '0) ||
                    (in_total_coverage == '0);

  always_comb begin
    ctl_nxt.valid    = accept;
    ctl_nxt.rejected = in_shared_chain || in_shared_anchor || zero_cov;
    if (in_shared_chain) begin
      ctl_nxt.verdict = V_SHARED_CHAIN;
    end else if (in_shared_anchor) begin
      ctl_nxt.verdict = V_SHARED_ANCHOR;
    end else begin
      ctl_nxt.verdict = V_ZERO_COVERAGE;
    end
  end

  // Carry the transaction's control alongside the lanes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < CTL_LAT; k++) ctl_r[k].valid <= 1'b0;
    end else begin
      ctl_r[0].valid <= ctl_nxt.valid;
      for (int k = 1; k < CTL_LAT; k++) ctl_r[k].valid <= ctl_r[k-1].valid;
    end
    ctl_r[0].rejected <= ctl_nxt.rejected;
    ctl_r[0].verdict  <= ctl_nxt.verdict;
    for (int k = 1; k < CTL_LAT; k++) begin
      ctl_r[k].rejected <= ctl_r[k-1].rejected;
      ctl_r[k].verdict  <= ctl_r[k-1].verdict;
    end
  end

  pcc_lane #(.COUNT_WIDTH(COUNT_WIDTH), .FRACTION_BITS(FRACTION_BITS)) u_lane00 (
    .clk (clk), .count_i (in_cell_00), .ent_i (in_entrance_coverage_0),
    .ext_i (in_exit_coverage_0), .total_i (in_total_coverage), .eps_i (eps_eff),
    .term_mix_o (mix00), .term_rnd_o (rnd00)
  );

  pcc_lane #(.COUNT_WIDTH(COUNT_WIDTH), .FRACTION_BITS(FRACTION_BITS)) u_lane01 (
    .clk (clk), .count_i (in_cell_01), .ent_i (in_entrance_coverage_0),
    .ext_i (in_exit_coverage_1), .total_i (in_total_coverage), .eps_i (eps_eff),
    .term_mix_o (mix01), .term_rnd_o (rnd01)
  );

  pcc_lane #(.COUNT_WIDTH(COUNT_WIDTH), .FRACTION_BITS(FRACTION_BITS)) u_lane10 (
    .clk (clk), .count_i (in_cell_10), .ent_i (in_entrance_coverage_1),
    .ext_i (in_exit_coverage_0), .total_i (in_total_coverage), .eps_i (eps_eff),
    .term_mix_o (mix10), .term_rnd_o (rnd10)
  );

  pcc_lane #(.COUNT_WIDTH(COUNT_WIDTH), .FRACTION_BITS(FRACTION_BITS)) u_lane11 (
    .clk (clk), .count_i (in_cell_11), .ent_i (in_entrance_coverage_1),
    .ext_i (in_exit_coverage_1), .total_i (in_total_coverage), .eps_i (eps_eff),
    .term_mix_o (mix11), .term_rnd_o (rnd11)
  );

  // In phase mixes the ideal model on the diagonal, out of phase off it
  assign terms_in  = {mix11, rnd10, rnd01, mix00};
  assign terms_out = {rnd11, mix10, mix01, rnd00};

  pcc_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl_i       (ctl_r[CTL_LAT-1]),
    .terms_in_i  (terms_in),
    .terms_out_i (terms_out),
    .threshold_i (threshold_r),
    .valid_o     (out_valid),
    .verdict_o   (out_verdict),
    .chi_in_o    (out_chi_in_phase),
    .chi_out_o   (out_chi_out_of_phase)
  );

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##OUT_LAT out_valid)
    else $error("accepted transaction did not produce a result on time");

  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !ctl_r[CTL_LAT-1].valid |-> ##2 !out_valid)
    else $error("result strobe without a transaction in flight");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_verdict == V_ZERO_COVERAGE || out_verdict == V_SHARED_CHAIN ||
                   out_verdict == V_SHARED_ANCHOR))
    |-> (out_chi_in_phase == '0 && out_chi_out_of_phase == '0))
    else $error("rejected transaction reported nonzero statistics");

endmodule
`default_nettype wire

@@ rtl/pcc_rand_div.sv @@
// Pipelined restoring divider for the random expected value, one quotient bit a stage.
`default_nettype none
module pcc_rand_div #(
  parameter int COUNT_WIDTH   = 16,
  parameter int FRACTION_BITS = 16,
  localparam int DW = 2 * COUNT_WIDTH + FRACTION_BITS,
  localparam int RW = (DW > pcc_pkg::RAND_W) ? pcc_pkg::RAND_W : DW
) (
  input  wire logic                          clk,
  input  wire logic [2*COUNT_WIDTH-1:0]      prod_i,
  input  wire logic [pcc_pkg::TOTAL_W-1:0]   total_i,
  output logic      [RW-1:0]                 rnd_o
);
  import pcc_pkg::*;

  logic [TOTAL_W-1:0] rem_r  [DW];
  logic [DW-1:0]      work_r [DW];
  logic [TOTAL_W-1:0] tot_r  [DW];

  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic [TOTAL_W-1:0] rem_in;
    logic [DW-1:0]      work_in;
    logic [TOTAL_W-1:0] tot_in;
    logic [TOTAL_W:0]   r2;
    logic [TOTAL_W:0]   diff;
    logic               ge;
    logic [TOTAL_W-1:0] rem_nxt;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign work_in = {prod_i, {FRACTION_BITS{1'b0}}};
      assign tot_in  = total_i;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign work_in = work_r[k-1];
      assign tot_in  = tot_r[k-1];
    end

    assign r2      = {rem_in, work_in[DW-1]};
    assign diff    = r2 - {1'b0, tot_in};
    assign ge      = r2 >= {1'b0, tot_in};
    assign rem_nxt = ge ? diff[TOTAL_W-1:0] : r2[TOTAL_W-1:0];

    always_ff @(posedge clk) begin
      rem_r[k]  <= rem_nxt;
      work_r[k] <= {work_in[DW-2:0], ge};
      tot_r[k]  <= tot_in;
    end
  end

  // Cap the quotient at the largest value the mixer takes
  if (DW > RAND_W) begin : g_cap
    assign rnd_o = (|work_r[DW-1][DW-1:RAND_W]) ? {RW{1'b1}} : work_r[DW-1][RW-1:0];
  end else begin : g_nocap
    assign rnd_o = work_r[DW-1][RW-1:0];
  end

endmodule
`default_nettype wire

@@ rtl/pcc_chi_term.sv @@
// One chi-square term: split square of the deviation, then a saturating pipelined divide.
`default_nettype none
module pcc_chi_term #(
  parameter int COUNT_WIDTH   = 16,
  parameter int FRACTION_BITS = 16,
  localparam int DW = 2 * COUNT_WIDTH + FRACTION_BITS,
  localparam int EW = (DW > pcc_pkg::RAND_W) ? pcc_pkg::RAND_W : DW
) (
  input  wire logic                        clk,
  input  wire logic [COUNT_WIDTH-1:0]      count_i,
  input  wire logic [EW-1:0]               expected_i,
  output logic      [pcc_pkg::CHI_W-1:0]   term_o
);
  import pcc_pkg::*;

  localparam int OW   = COUNT_WIDTH + FRACTION_BITS;
  localparam int HW   = (EW + 1) / 2;
  localparam int SW   = 4 * HW;
  localparam int HIW  = SW - CHI_W;
  localparam int CMPW = (HIW > EW) ? HIW : EW;

  logic [OW-1:0]   obs_w;
  logic [EW-1:0]   obs;
  logic [EW-1:0]   d_nxt;
  logic [2*HW-1:0] d_ext;

  logic [EW-1:0]   d_r, e0_r;
  logic [HW-1:0]   dl1_r, dh1_r;
  logic [2*HW-1:0] pll1_r;
  logic [EW-1:0]   e1_r;
  logic [HW-1:0]   dh2_r;
  logic [2*HW-1:0] pll2_r, plh2_r;
  logic [EW-1:0]   e2_r;
  logic [2*HW-1:0] pll3_r, plh3_r, phh3_r;
  logic [EW-1:0]   e3_r;
  logic [SW-1:0]   sq4_r;
  logic [EW-1:0]   e4_r;

  logic [EW-1:0]    rem_r  [CHI_W+1];
  logic [CHI_W-1:0] work_r [CHI_W+1];
  logic [EW-1:0]    e_r    [CHI_W+1];
  logic             sat_r  [CHI_W+1];

  logic [SW-1:0]   sq_nxt;
  logic [CMPW-1:0] hi_ext, e_ext;
  logic            sat_nxt;

  assign obs_w = {count_i, {FRACTION_BITS{1'b0}}};
  assign obs   = EW'(obs_w);
  assign d_nxt = (obs >= expected_i) ? obs - expected_i : expected_i - obs;
  assign d_ext = (2*HW)'(d_r);

  assign sq_nxt = (SW'(phh3_r) << (2*HW)) + (SW'(plh3_r) << (HW+1)) + SW'(pll3_r);

  assign hi_ext  = CMPW'(sq4_r[SW-1:CHI_W]);
  assign e_ext   = CMPW'(e4_r);
  // A quotient that reaches 2^40 saturates; a zero divisor always lands here
  assign sat_nxt = hi_ext >= e_ext;

  always_ff @(posedge clk) begin
    d_r    <= d_nxt;
    e0_r   <= expected_i;
    dl1_r  <= d_ext[HW-1:0];
    dh1_r  <= d_ext[2*HW-1:HW];
    pll1_r <= (2*HW)'(d_ext[HW-1:0]) * (2*HW)'(d_ext[HW-1:0]);
    e1_r   <= e0_r;
    dh2_r  <= dh1_r;
    pll2_r <= pll1_r;
    plh2_r <= (2*HW)'(dh1_r) * (2*HW)'(dl1_r);
    e2_r   <= e1_r;
    pll3_r <= pll2_r;
    plh3_r <= plh2_r;
    phh3_r <= (2*HW)'(dh2_r) * (2*HW)'(dh2_r);
    e3_r   <= e2_r;
    sq4_r  <= sq_nxt;
    e4_r   <= e3_r;
    rem_r[0]  <= sat_nxt ? '0 : hi_ext[EW-1:0];
    work_r[0] <= sq4_r[CHI_W-1:0];
    e_r[0]    <= e4_r;
    sat_r[0]  <= sat_nxt;
  end

  for (genvar k = 1; k <= CHI_W; k++) begin : g_div
    logic [EW:0]   r2;
    logic [EW:0]   diff;
    logic          ge;
    logic [EW-1:0] rem_nxt;

    assign r2      = {rem_r[k-1], work_r[k-1][CHI_W-1]};
    assign diff    = r2 - {1'b0, e_r[k-1]};
    assign ge      = r2 >= {1'b0, e_r[k-1]};
    assign rem_nxt = ge ? diff[EW-1:0] : r2[EW-1:0];

    always_ff @(posedge clk) begin
      rem_r[k]  <= rem_nxt;
      work_r[k] <= {work_r[k-1][CHI_W-2:0], ge};
      e_r[k]    <= e_r[k-1];
      sat_r[k]  <= sat_r[k-1];
    end
  end

  assign term_o = sat_r[CHI_W] ? CHI_MAX : work_r[CHI_W];

endmodule
`default_nettype wire

@@ rtl/pcc_lane.sv @@
// One cell lane: random expectation, epsilon mix and the two chi-square terms of the cell.
`default_nettype none
module pcc_lane #(
  parameter int COUNT_WIDTH   = 16,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic [COUNT_WIDTH-1:0]      count_i,
  input  wire logic [COUNT_WIDTH-1:0]      ent_i,
  input  wire logic [COUNT_WIDTH-1:0]      ext_i,
  input  wire logic [pcc_pkg::TOTAL_W-1:0] total_i,
  input  wire logic [pcc_pkg::EPS_W-1:0]   eps_i,
  output logic      [pcc_pkg::CHI_W-1:0]   term_mix_o,
  output logic      [pcc_pkg::CHI_W-1:0]   term_rnd_o
);
  import pcc_pkg::*;

  localparam int DW = 2 * COUNT_WIDTH + FRACTION_BITS;
  localparam int RW = (DW > RAND_W) ? RAND_W : DW;
  localparam int EW = RW;
  localparam int IW = COUNT_WIDTH + FRACTION_BITS;
  localparam int PW = RW + EPS_W;

  logic [2*COUNT_WIDTH-1:0] prod_r;
  logic [TOTAL_W-1:0]       tot_r;
  logic [IW-1:0]            ideal_r;
  logic [COUNT_WIDTH-1:0]   cnt_r;
  logic [IW-1:0]            ideal_dly_r [DW];
  logic [COUNT_WIDTH-1:0]   cnt_dly_r   [DW+2];

  logic [COUNT_WIDTH:0]     cov_sum;
  logic [RW-1:0]            rnd;
  logic [EPS_W-1:0]         wgt;
  logic [PW-1:0]            prod_rnd_r;
  logic [IW+EPS_W-1:0]      prod_ideal_r;
  logic [PW:0]              mix_sum;
  logic [EW-1:0]            mix_ideal_r, mix_rnd_r;

  assign cov_sum = {1'b0, ent_i} + {1'b0, ext_i};
  assign wgt     = EPS_ONE - eps_i;
  assign mix_sum = (PW+1)'(prod_rnd_r) + (PW+1)'(prod_ideal_r);

  always_ff @(posedge clk) begin
    prod_r  <= (2*COUNT_WIDTH)'(ent_i) * (2*COUNT_WIDTH)'(ext_i);
    tot_r   <= total_i;
    ideal_r <= {cov_sum, {(FRACTION_BITS-1){1'b0}}};
    cnt_r   <= count_i;
    ideal_dly_r[0] <= ideal_r;
    for (int k = 1; k < DW; k++) ideal_dly_r[k] <= ideal_dly_r[k-1];
    cnt_dly_r[0] <= cnt_r;
    for (int k = 1; k < DW + 2; k++) cnt_dly_r[k] <= cnt_dly_r[k-1];
    prod_rnd_r   <= PW'(eps_i) * PW'(rnd);
    prod_ideal_r <= (IW+EPS_W)'(wgt) * (IW+EPS_W)'(ideal_dly_r[DW-1]);
    mix_ideal_r  <= mix_sum[EPS_BITS +: EW];
    mix_rnd_r    <= prod_rnd_r[EPS_BITS +: EW];
  end

  pcc_rand_div #(
    .COUNT_WIDTH   (COUNT_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_div (
    .clk     (clk),
    .prod_i  (prod_r),
    .total_i (tot_r),
    .rnd_o   (rnd)
  );

  pcc_chi_term #(
    .COUNT_WIDTH   (COUNT_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_chi_mix (
    .clk        (clk),
    .count_i    (cnt_dly_r[DW+1]),
    .expected_i (mix_ideal_r),
    .term_o     (term_mix_o)
  );

  pcc_chi_term #(
    .COUNT_WIDTH   (COUNT_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_chi_rnd (
    .clk        (clk),
    .count_i    (cnt_dly_r[DW+1]),
    .expected_i (mix_rnd_r),
    .term_o     (term_rnd_o)
  );

endmodule
`default_nettype wire

@@ rtl/pcc_merge.sv @@
// Merging stage: saturating sums of the lane terms and the threshold decision.
`default_nettype none
module pcc_merge (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire pcc_pkg::pcc_ctl_t                 ctl_i,
  input  wire logic [3:0][pcc_pkg::CHI_W-1:0]    terms_in_i,
  input  wire logic [3:0][pcc_pkg::CHI_W-1:0]    terms_out_i,
  input  wire logic [pcc_pkg::CHI_W-1:0]         threshold_i,
  output logic                                   valid_o,
  output logic      [pcc_pkg::VERDICT_W-1:0]     verdict_o,
  output logic      [pcc_pkg::CHI_W-1:0]         chi_in_o,
  output logic      [pcc_pkg::CHI_W-1:0]         chi_out_o
);
  import pcc_pkg::*;

  localparam int SUMW = CHI_W + 2;

  logic [SUMW-1:0]      sum_in, sum_out;
  pcc_ctl_t             ctl1_r;
  logic [CHI_W-1:0]     sin_r, sout_r;
  logic                 valid_r;
  logic [VERDICT_W-1:0] verdict_r, verdict_nxt;
  logic [CHI_W-1:0]     chi_in_r, chi_out_r;

  assign sum_in  = SUMW'(terms_in_i[0]) + SUMW'(terms_in_i[1])
                 + SUMW'(terms_in_i[2]) + SUMW'(terms_in_i[3]);
  assign sum_out = SUMW'(terms_out_i[0]) + SUMW'(terms_out_i[1])
                 + SUMW'(terms_out_i[2]) + SUMW'(terms_out_i[3]);

  always_comb begin
    if (ctl1_r.rejected) begin
      verdict_nxt = ctl1_r.verdict;
    end else if (sin_r < threshold_i && sout_r > threshold_i) begin
      verdict_nxt = V_IN_PHASE;
    end else if (sin_r > threshold_i && sout_r < threshold_i) begin
      verdict_nxt = V_OUT_OF_PHASE;
    end else begin
      verdict_nxt = V_UNRELIABLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r.valid <= 1'b0;
      valid_r      <= 1'b0;
    end else begin
      ctl1_r.valid <= ctl_i.valid;
      valid_r      <= ctl1_r.valid;
    end
    ctl1_r.rejected <= ctl_i.rejected;
    ctl1_r.verdict  <= ctl_i.verdict;
    sin_r  <= (sum_in  > SUMW'(CHI_MAX)) ? CHI_MAX : sum_in[CHI_W-1:0];
    sout_r <= (sum_out > SUMW'(CHI_MAX)) ? CHI_MAX : sum_out[CHI_W-1:0];
    verdict_r <= verdict_nxt;
    // Early rejections report zero statistics
    chi_in_r  <= ctl1_r.rejected ? '0 : sin_r;
    chi_out_r <= ctl1_r.rejected ? '0 : sout_r;
  end

  assign valid_o   = valid_r;
  assign verdict_o = verdict_r;
  assign chi_in_o  = chi_in_r;
  assign chi_out_o = chi_out_r;

endmodule
`default_nettype wire
